FILE: sv/sacl_pkg.sv
package sacl_pkg;

  // Fixed field widths and address split
  localparam int LINE_OFFSET_BITS = 4;
  localparam int COUNT_W          = 32;
  localparam int CFG_W            = 4;
  localparam int CFG_IDX_W        = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 4'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] SET_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] WAYS_RST     = 4'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } sacl_state_e;

endpackage

FILE: sv/sacl_ram.sv
module sacl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/set_assoc_cache_lru_replace_core.sv
// Channel   Signals                                        Direction
// cfg       cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i   in
// in        in_valid_i/in_ready_o, address_i                   in
// out       out_valid_o/out_ready_i, hit_o, access_count_o,    out
//           miss_count_o
//
// Each word: a hit runs the search and then the recency shift; a miss into an
// empty set writes at once, one into a set with room appends after the search,
// and one into a full set shifts out the oldest tag. The single tag RAM port
// pair sets the pace: the search reads one slot per cycle, and the recency
// shift rewrites one slot per cycle. After reset the fill-count RAM is cleared,
// one set a cycle for all 2**floor(log2(MAX_SETS)) sets; in_ready_o stays low
// meanwhile. A result waits in the output register; the next word is taken and
// worked on while it waits, and only the final update waits for out_ready_i.
module set_assoc_cache_lru_replace_core
  import sacl_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ADDR_BITS-1:0] address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [COUNT_W-1:0]   access_count_o,
  output logic [COUNT_W-1:0]   miss_count_o
);

  localparam int EFF_BITS     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W        = EFF_BITS - LINE_OFFSET_BITS;
  localparam int MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS        = 1 << MAX_SET_BITS;
  localparam int FILL_W       = $clog2(MAX_WAYS + 1);
  localparam int TAG_DEPTH    = MAX_SETS * MAX_WAYS;
  localparam int TAG_AW       = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

  localparam logic [SET_W-1:0]   CLR_LAST  = SET_W'(NSETS - 1);
  localparam logic [CFG_W-1:0]   SET_B_MAX = CFG_W'(MAX_SET_BITS);
  localparam logic [FILL_W-1:0]  WAYS_MAX  = FILL_W'(MAX_WAYS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [TAG_AW-1:0] tag_index(input logic [SET_W-1:0]  s,
                                                  input logic [FILL_W-1:0] w);
    return TAG_AW'(32'(s) * 32'(MAX_WAYS) + 32'(w));
  endfunction

  sacl_state_e state_q, state_d;

  logic [CFG_W-1:0]   set_bits_q, ways_q;
  logic [SET_W-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d;
  logic [COUNT_W-1:0] access_q, access_d, miss_q, miss_d;

  logic [SET_W-1:0]   set_q, set_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  ptr_q, ptr_d;
  logic               found_q, found_d;

  // effective configuration
  logic [CFG_W-1:0]  eff_bits;
  logic [FILL_W-1:0] eff_ways;
  logic [4:0]        ways_ext;

  assign eff_bits = (set_bits_q > SET_B_MAX) ? SET_B_MAX : set_bits_q;
  assign ways_ext = 5'(ways_q);

  always_comb begin
    if (ways_q == '0) begin
      eff_ways = FILL_W'(1);
    end else if (ways_ext > 5'(MAX_WAYS)) begin
      eff_ways = WAYS_MAX;
    end else begin
      eff_ways = FILL_W'(ways_q);
    end
  end

  // address split
  logic [EFF_BITS-1:0] addr_eff;
  logic [TAG_W-1:0]    line_addr, set_mask;
  logic [SET_W-1:0]    set_in;
  logic [TAG_W-1:0]    tag_in;

  assign addr_eff  = address_i[EFF_BITS-1:0];
  assign line_addr = addr_eff[EFF_BITS-1:LINE_OFFSET_BITS];
  assign set_mask  = ~({TAG_W{1'b1}} << eff_bits);
  assign set_in    = SET_W'(line_addr & set_mask);
  assign tag_in    = line_addr >> eff_bits;

  // memory ports
  logic              fill_we;
  logic [SET_W-1:0]  fill_waddr, fill_raddr;
  logic [FILL_W-1:0] fill_wdata, fill_rdata;
  logic              tag_we;
  logic [FILL_W-1:0] tag_wway, tag_rway;
  logic [TAG_W-1:0]  tag_wdata, tag_rdata;

  sacl_ram #(
    .W     (FILL_W),
    .DEPTH (NSETS),
    .AW    (SET_W)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  sacl_ram #(
    .W     (TAG_W),
    .DEPTH (TAG_DEPTH),
    .AW    (TAG_AW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_index(set_q, tag_wway)),
    .wdata_i (tag_wdata),
    .raddr_i (tag_index(set_q, tag_rway)),
    .rdata_o (tag_rdata)
  );

  // shared compare and slot status
  logic match, last;
  assign match = (tag_rdata == tag_q);
  assign last  = (ptr_q == FILL_W'(fill_q - 1'b1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_FILL;
      ST_FILL:   state_d = (fill_rdata == '0) ? ST_DONE : ST_SEARCH;
      ST_SEARCH: begin
        if (match) begin
          state_d = ST_SHIFT;
        end else if (last) begin
          state_d = (fill_q < eff_ways) ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT:  if (last) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // datapath control
  always_comb begin
    in_ready_o  = 1'b0;
    fill_we     = 1'b0;
    fill_waddr  = set_q;
    fill_wdata  = '0;
    fill_raddr  = set_q;
    tag_we      = 1'b0;
    tag_wway    = ptr_q;
    tag_wdata   = tag_q;
    tag_rway    = FILL_W'(ptr_q + 1'b1);
    clr_d       = clr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    hit_d       = hit_q;
    access_d    = access_q;
    miss_d      = miss_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        clr_d      = SET_W'(clr_q + 1'b1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        fill_raddr = set_in;
        set_d      = set_in;
        tag_d      = tag_in;
      end
      ST_FILL: begin
        fill_d   = fill_rdata;
        ptr_d    = '0;
        found_d  = 1'b0;
        tag_rway = '0;
        // empty set: first tag goes straight in
        if (fill_rdata == '0) begin
          tag_we     = 1'b1;
          tag_wway   = '0;
          fill_we    = 1'b1;
          fill_wdata = FILL_W'(1);
        end
      end
      ST_SEARCH: begin
        if (match) begin
          found_d = 1'b1;
        end else if (last) begin
          if (fill_q < eff_ways) begin
            // room left: append at the newest end
            tag_we     = 1'b1;
            tag_wway   = fill_q;
            fill_we    = 1'b1;
            fill_wdata = FILL_W'(fill_q + 1'b1);
          end else begin
            // full: evict the oldest by shifting from slot zero
            ptr_d    = '0;
            tag_rway = FILL_W'(1);
          end
        end else begin
          ptr_d = FILL_W'(ptr_q + 1'b1);
        end
      end
      ST_SHIFT: begin
        tag_we = 1'b1;
        if (!last) begin
          tag_wdata = tag_rdata;
          tag_rway  = FILL_W'(ptr_q + 2'd2);
          ptr_d     = FILL_W'(ptr_q + 1'b1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d       = found_q;
          access_d    = sat_inc(access_q);
          miss_d      = found_q ? miss_q : sat_inc(miss_q);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      access_q    <= '0;
      miss_q      <= '0;
      set_bits_q  <= SET_BITS_RST;
      ways_q      <= WAYS_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      access_q    <= access_d;
      miss_q      <= miss_d;
      if (cfg_valid_i && cfg_index_i == CFG_SET_BITS) set_bits_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_WAYS) ways_q <= cfg_data_i;
    end
  end

  // per-word working registers
  always_ff @(posedge clk_i) begin
    set_q   <= set_d;
    tag_q   <= tag_d;
    fill_q  <= fill_d;
    ptr_q   <= ptr_d;
    found_q <= found_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign access_count_o = access_q;
  assign miss_count_o   = miss_q;

endmodule

FILE: sv/sacl_checker.sv
module sacl_checker
  import sacl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic [COUNT_W-1:0] access_count_o,
  input logic [COUNT_W-1:0] miss_count_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o)
      && $stable(access_count_o) && $stable(miss_count_o))
    else $error("result word changed while stalled");

  // running counts never go backwards
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> access_count_o >= $past(access_count_o)
      && miss_count_o >= $past(miss_count_o))
    else $error("access or miss count decreased");

  // misses never outnumber accesses
  a_miss_le_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_count_o <= access_count_o)
    else $error("miss count above access count");

  // one lookup at a time: no word taken right after another
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a lookup is in progress");

endmodule

bind set_assoc_cache_lru_replace_core sacl_checker u_sacl_checker (.*);

FILE: bench/set_assoc_cache_lru_replace_core_test.sv
module set_assoc_cache_lru_replace_core_test;
  import sacl_pkg::*;

  localparam int MAX_SETS        = 1024;
  localparam int MAX_WAYS        = 8;
  localparam int ADDR_BITS       = 32;
  localparam int MAX_SET_BITS    = $clog2(MAX_SETS);
  localparam int FILL_W          = $clog2(MAX_WAYS + 1);
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASES          = 12;
  localparam int PHASE_WORDS     = 160;
  localparam int CALM_PHASES     = 2;
  localparam int RECENT_DEPTH    = 24;
  localparam int REPORT_LIMIT    = 10;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd7;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] accesses;
    logic [COUNT_W-1:0] misses;
  } lookup_t;

  // LRU tag store mirror plus the queue of lookups still owed by the block
  class lru_tag_model;
    logic [ADDR_BITS-1:0] tag_store [MAX_SETS][MAX_WAYS];
    logic [FILL_W-1:0]    fill [MAX_SETS];
    logic [COUNT_W-1:0]   accesses;
    logic [COUNT_W-1:0]   misses;
    logic [CFG_W-1:0]     set_bits;
    logic [CFG_W-1:0]     ways;
    lookup_t              pending[$];
    int                   errors;
    int                   words_checked;
    int                   hits_seen;

    function new();
      foreach (fill[i]) fill[i] = '0;
      accesses      = '0;
      misses        = '0;
      set_bits      = SET_BITS_RST;
      ways          = WAYS_RST;
      errors        = 0;
      words_checked = 0;
      hits_seen     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_SET_BITS: set_bits = data;
        CFG_WAYS:     ways = data;
        default: ;
      endcase
    endfunction

    // set bits clamp to what the set array can hold
    function int eff_bits();
      if (int'(set_bits) > MAX_SET_BITS) return MAX_SET_BITS;
      return int'(set_bits);
    endfunction

    // zero ways acts as one, too many acts as the built count
    function int eff_ways();
      if (int'(ways) == 0) return 1;
      if (int'(ways) > MAX_WAYS) return MAX_WAYS;
      return int'(ways);
    endfunction

    function void note_address(logic [ADDR_BITS-1:0] addr);
      int                   bits;
      int                   nways;
      int                   set_idx;
      int                   nfill;
      int                   slot;
      logic [ADDR_BITS-1:0] tag;
      logic [ADDR_BITS-1:0] set_mask;
      lookup_t              res;
      bits     = eff_bits();
      nways    = eff_ways();
      set_mask = (32'd1 << bits) - 32'd1;
      set_idx  = int'((addr >> LINE_OFFSET_BITS) & set_mask);
      tag      = addr >> (LINE_OFFSET_BITS + bits);
      nfill    = int'(fill[set_idx]);
      slot     = -1;
      for (int i = 0; i < nfill; i++) begin
        if (slot < 0 && tag_store[set_idx][i] == tag) slot = i;
      end
      res.hit = (slot >= 0);
      if (slot >= 0) begin
        // hit: close the gap and move the tag to the newest slot
        for (int j = slot; j < nfill - 1; j++) tag_store[set_idx][j] = tag_store[set_idx][j + 1];
        tag_store[set_idx][nfill - 1] = tag;
      end else if (nfill < nways) begin
        tag_store[set_idx][nfill] = tag;
        fill[set_idx] = FILL_W'(nfill + 1);
      end else begin
        // full (or over-full after ways shrank): drop oldest
        for (int j = 0; j < nfill - 1; j++) tag_store[set_idx][j] = tag_store[set_idx][j + 1];
        tag_store[set_idx][nfill - 1] = tag;
      end
      if (!res.hit && misses != '1) misses = misses + 1'b1;
      if (accesses != '1) accesses = accesses + 1'b1;
      res.accesses = accesses;
      res.misses   = misses;
      pending.insert(pending.size(), res);
    endfunction

    function void check_lookup(logic hit, logic [COUNT_W-1:0] acc, logic [COUNT_W-1:0] mis);
      lookup_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result word with no lookup pending: hit=%0b accesses=%0d misses=%0d",
                   hit, acc, mis);
        return;
      end
      want = pending.pop_front();
      words_checked++;
      if (want.hit) hits_seen++;
      if (hit !== want.hit || acc !== want.accesses || mis !== want.misses) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("lookup %0d: expected hit=%0b acc=%0d miss=%0d, got hit=%0b acc=%0d miss=%0d",
                   words_checked, want.hit, want.accesses, want.misses, hit, acc, mis);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ADDR_BITS-1:0] address_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 hit_o;
  logic [COUNT_W-1:0]   access_count_o;
  logic [COUNT_W-1:0]   miss_count_o;

  lru_tag_model         model;
  logic [ADDR_BITS-1:0] recent_addrs[$];
  bit                   idling_on;
  int                   idle_cycles = 0;
  int                   reg_writes;

  set_assoc_cache_lru_replace_core #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .access_count_o(access_count_o),
    .miss_count_o  (miss_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: predict on accepted addresses, check result words, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) model.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) model.note_address(address_i);
      if (out_valid_o && out_ready_i) model.check_lookup(hit_o, access_count_o, miss_count_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("set_assoc_cache_lru_replace_core_test: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result sink: random stall bursts while idling is on
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
    end
  end

  // drop valid and wait until every lookup has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (model.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  // send one address word, with an optional gap before it
  task automatic lookup(input logic [ADDR_BITS-1:0] addr);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly conflicting tags in a few sets and reuse of recent lines, some noise
  function automatic logic [ADDR_BITS-1:0] next_address();
    int                   r;
    int                   bits;
    int                   nsets;
    int                   set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic [ADDR_BITS-1:0] addr;
    r     = $urandom_range(0, 99);
    bits  = model.eff_bits();
    nsets = 1 << bits;
    if (r < 12) begin
      addr = $urandom;
    end else if (r < 45 && recent_addrs.size() > 0) begin
      addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      addr[LINE_OFFSET_BITS-1:0] = LINE_OFFSET_BITS'($urandom_range(0, 15));
    end else begin
      if ($urandom_range(0, 3) == 0) set_idx = $urandom_range(0, nsets - 1);
      else set_idx = $urandom_range(0, (nsets > 4) ? 3 : nsets - 1);
      if ($urandom_range(0, 5) == 0) tag = $urandom >> (LINE_OFFSET_BITS + bits);
      else tag = $urandom_range(0, model.eff_ways() + 2);
      addr = (tag << (LINE_OFFSET_BITS + bits)) |
             (ADDR_BITS'(set_idx) << LINE_OFFSET_BITS) |
             ADDR_BITS'($urandom_range(0, 15));
    end
    recent_addrs.insert(recent_addrs.size(), addr);
    if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
    return addr;
  endfunction

  // main sequence
  initial begin
    int nb;
    int nw;
    model       = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    address_i   = '0;
    idling_on   = 1'b1;
    reg_writes  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: 6 set bits, 4 ways; address extremes and a full set
    lookup(32'h0000_0000);
    lookup(32'h0000_000F);
    lookup(32'hFFFF_FFFF);
    lookup(32'hFFFF_FFF0);
    lookup(32'h0000_0400);
    lookup(32'h0000_0800);
    lookup(32'h0000_0C00);
    lookup(32'h0000_0000);  // hit on the oldest slot
    lookup(32'h0000_1000);  // full set, evicts LRU
    lookup(32'h0000_0400);  // evicted tag misses

    // single set, eight ways
    write_reg(CFG_SET_BITS, 4'd0);
    write_reg(CFG_WAYS, 4'd8);
    for (int t = 0; t < 6; t++) lookup(ADDR_BITS'(t) << LINE_OFFSET_BITS);
    lookup(32'h0000_0020);  // hit in the middle

    // ways lowered under the current fill
    write_reg(CFG_WAYS, 4'd2);
    lookup(32'h0000_0100);
    lookup(32'h0000_0050);

    // unmapped index, set bits and ways out of range
    write_reg(CFG_UNUSED, 4'd3);
    write_reg(CFG_SET_BITS, 4'd15);
    write_reg(CFG_WAYS, 4'd0);
    lookup(32'h1234_5678);
    lookup(32'h1234_5670);
    lookup(32'hABCD_5678);  // same set, one way: evicts
    lookup(32'h1234_5678);

    // random phases, each under new settings; last ones without idling
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - CALM_PHASES) idling_on = 1'b0;
      case (p)
        0: begin
          nb = 10;
          nw = 8;
        end
        1: begin
          nb = 0;
          nw = 1;
        end
        2: begin
          nb = 1;
          nw = 15;
        end
        3: begin
          nb = 15;
          nw = 3;
        end
        default: begin
          nb = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 15);
          nw = $urandom_range(0, 15);
        end
      endcase
      write_reg(CFG_SET_BITS, CFG_W'(nb));
      write_reg(CFG_WAYS, CFG_W'(nw));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_WAYS) + 1, 15)),
                  CFG_W'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_WORDS; n++) lookup(next_address());
    end

    // drain and settle
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("%0d lookups checked, %0d hits and %0d misses, over %0d register writes",
             model.words_checked, model.hits_seen, model.words_checked - model.hits_seen,
             reg_writes);
    $display("set bits and ways swept across and beyond range, with stalls on both channels");
    if (model.errors == 0) begin
      $display("set_assoc_cache_lru_replace_core_test: clean");
    end else begin
      $display("set_assoc_cache_lru_replace_core_test: errors");
    end
    $finish;
  end

endmodule
